[hw/rtl/ppf_pkg.sv]
package ppf_pkg;

    localparam int unsigned MAX_LOOP_LEN = 1024;
    localparam int unsigned CNT_W        = $clog2(MAX_LOOP_LEN + 1);
    localparam int unsigned POS_W        = 24;
    localparam int unsigned CSUM_W       = 35;
    localparam int unsigned NSUM_W       = 61;
    localparam int unsigned NRM_W        = 32;
    localparam int unsigned SQ_W         = 120;
    localparam int unsigned LEN_W        = 60;
    localparam int unsigned MIN_LEN_W    = 32;
    localparam logic [MIN_LEN_W-1:0] MIN_LEN_RESET = 32'd4295;
    localparam logic [NRM_W-1:0] NRM_ONE = 32'h4000_0000;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FEW      = 2'd1;
    localparam logic [1:0] ST_DEGEN    = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

endpackage

[hw/rtl/ppf_divider.sv]
module ppf_divider (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ppf_pkg::SQ_W-1:0]    i_num,
    input  logic [ppf_pkg::LEN_W-1:0]   i_den,
    input  logic [6:0]                  i_bits,
    output logic                        o_done,
    output logic [ppf_pkg::LEN_W+1:0]   o_quot
);

    logic                              r_busy, n_busy;
    logic [6:0]                        r_cnt, n_cnt;
    logic [ppf_pkg::SQ_W-1:0]          r_num, n_num;
    logic [ppf_pkg::LEN_W:0]           r_rem, n_rem;
    logic [ppf_pkg::LEN_W+1:0]         r_quot, n_quot;
    logic [ppf_pkg::LEN_W:0]           w_shift;
    logic                              r_done;

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_rem  = r_rem;
        n_quot = r_quot;
        w_shift = {r_rem[ppf_pkg::LEN_W-1:0], r_num[ppf_pkg::SQ_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = i_bits;
            n_num  = i_num << (7'd120 - i_bits);
            n_rem  = '0;
            n_quot = '0;
        end else if (r_busy) begin
            n_num  = r_num << 1;
            if (w_shift >= {1'b0, i_den}) begin
                n_rem  = w_shift - {1'b0, i_den};
                n_quot = {r_quot[ppf_pkg::LEN_W:0], 1'b1};
            end else begin
                n_rem  = w_shift;
                n_quot = {r_quot[ppf_pkg::LEN_W:0], 1'b0};
            end
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= r_busy && !n_busy && !i_start;
            r_cnt  <= n_cnt;
        end
        r_num  <= n_num;
        r_rem  <= n_rem;
        r_quot <= n_quot;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

`ifndef NO_ASSERTIONS
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_rem < {1'b0, i_den}) else $error("remainder not reduced");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("done while busy");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy) else $error("start lost");
`endif

endmodule

[hw/rtl/polygon_plane_fit_unit.sv]
// Polygon plane fit: centroid and unit normal of a closed vertex loop.
// Input channel: i_valid/o_stall with i_pos_x/y/z (signed Q8.16) and
// i_last_vertex. The first vertex of a loop is stored as the loop's start. Each
// further non-last vertex is accumulated through one shared 32x32 multiplier
// (one Newell product per cycle); no new vertex is taken until its pair is done.
// On the last vertex the loop pair and then the closing pair are accumulated,
// unless the loop is overlong. The squared length is summed from three 60x60
// products, each as four 32-bit partial products. The length comes from a
// 60-step bit-serial square root. The three normal terms and three centroids
// then share one 120-step restoring divider. A degenerate loop skips the
// divider, and a short or an overlong loop skips the length and the divider.
// Output channel: o_valid/i_stall carries one result per loop; the held
// result stays put while i_stall is high and no new vertex is taken
// until it has transferred.
// i_cfg_we/i_cfg_data write min_normal_length (unsigned Q0.32, reset 4295).
// Reset (i_rst_n low, synchronous) clears the loop state and the result
// valid.
module polygon_plane_fit_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic signed [23:0]  i_pos_x,
    input  logic signed [23:0]  i_pos_y,
    input  logic signed [23:0]  i_pos_z,
    input  logic                i_last_vertex,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [23:0]  o_center_x,
    output logic signed [23:0]  o_center_y,
    output logic signed [23:0]  o_center_z,
    output logic signed [31:0]  o_normal_x,
    output logic signed [31:0]  o_normal_y,
    output logic signed [31:0]  o_normal_z,
    output logic [1:0]          o_status,
    input  logic                i_cfg_we,
    input  logic [31:0]         i_cfg_data
);

    localparam int unsigned NW = ppf_pkg::NSUM_W;
    localparam int unsigned CW = ppf_pkg::CSUM_W;
    localparam int unsigned LW = ppf_pkg::LEN_W;
    localparam int unsigned SW = ppf_pkg::SQ_W;
    localparam int unsigned KW = ppf_pkg::CNT_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PAIR  = 4'd1;
    localparam logic [3:0] S_CLOSE = 4'd2;
    localparam logic [3:0] S_SQ    = 4'd3;
    localparam logic [3:0] S_SQRT  = 4'd4;
    localparam logic [3:0] S_SQRT2 = 4'd5;
    localparam logic [3:0] S_DIVN  = 4'd6;
    localparam logic [3:0] S_WAITN = 4'd7;
    localparam logic [3:0] S_DIVC  = 4'd8;
    localparam logic [3:0] S_WAITC = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0]                 r_state;
    logic [31:0]                r_min_len;
    logic signed [23:0]         r_first [3];
    logic signed [23:0]         r_prev [3];
    logic signed [23:0]         r_cur [3];
    logic signed [CW-1:0]       r_csum [3];
    logic signed [NW-1:0]       r_nsum [3];
    logic [KW-1:0]              r_count;
    logic                       r_ovf;
    logic                       r_last;
    logic [1:0]                 r_k;
    logic [3:0]                 r_ph;
    logic [SW-1:0]              r_sq;
    logic [LW-1:0]              r_len;
    logic [LW-1:0]              r_cand;
    logic [5:0]                 r_bit;
    logic [LW-1:0]              r_ma, r_mb;
    logic [63:0]                r_prod;
    logic [SW-1:0]              r_acc;
    logic [1:0]                 r_status;
    logic signed [23:0]         r_cen [3];
    logic signed [31:0]         r_nrm [3];
    logic                       r_ovalid;
    logic signed [23:0]         r_out_cx, r_out_cy, r_out_cz;
    logic signed [31:0]         r_out_nx, r_out_ny, r_out_nz;
    logic [1:0]                 r_out_st;

    logic [31:0]                w_ma, w_mb;
    logic [63:0]                w_prod;
    logic signed [24:0]         w_diff, w_sum;
    logic signed [24:0]         w_a, w_b, w_c, w_d;
    logic [NW-1:0]              w_nmag;
    logic [CW-1:0]              w_cmag;
    logic                       w_take;
    logic                       w_degen;
    logic [31:0]                w_nq;

    logic                       r_dstart;
    logic [SW-1:0]              r_dnum;
    logic [LW-1:0]              r_dden;
    logic [6:0]                 r_dbits;
    logic                       w_ddone;
    logic [LW+1:0]              w_dquot;

    ppf_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_dstart),
        .i_num   (r_dnum),
        .i_den   (r_dden),
        .i_bits  (r_dbits),
        .o_done  (w_ddone),
        .o_quot  (w_dquot)
    );

    assign w_take = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);
    assign w_degen = (r_len == '0) || (r_len < LW'(r_min_len));
    assign w_nq = (w_dquot > (LW+2)'(ppf_pkg::NRM_ONE)) ? ppf_pkg::NRM_ONE : w_dquot[31:0];

    // Newell pair selection: a = prev, b = current (or first when closing)
    always_comb begin
        w_a = '0; w_b = '0; w_c = '0; w_d = '0;
        case (r_k)
            2'd0: begin
                w_a = 25'(r_prev[1]); w_b = 25'(r_cur[1]);
                w_c = 25'(r_prev[2]); w_d = 25'(r_cur[2]);
            end
            2'd1: begin
                w_a = 25'(r_prev[2]); w_b = 25'(r_cur[2]);
                w_c = 25'(r_prev[0]); w_d = 25'(r_cur[0]);
            end
            default: begin
                w_a = 25'(r_prev[0]); w_b = 25'(r_cur[0]);
                w_c = 25'(r_prev[1]); w_d = 25'(r_cur[1]);
            end
        endcase
        w_diff = w_a - w_b;
        w_sum  = w_c + w_d;
    end

    always_comb begin
        w_nmag = r_nsum[r_k][NW-1] ? NW'(-r_nsum[r_k]) : NW'(r_nsum[r_k]);
        w_cmag = r_csum[r_k][CW-1] ? CW'(-r_csum[r_k]) : CW'(r_csum[r_k]);
    end

    // Shared 32x32 unsigned multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_PAIR, S_CLOSE: begin
                w_ma = w_diff[24] ? 32'(-w_diff) : 32'(w_diff);
                w_mb = w_sum[24] ? 32'(-w_sum) : 32'(w_sum);
            end
            S_SQ, S_SQRT2: begin
                case (r_ph[1:0])
                    2'd0:    begin w_ma = r_ma[31:0];          w_mb = r_mb[31:0]; end
                    2'd1:    begin w_ma = r_ma[31:0];          w_mb = 32'(r_mb[LW-1:32]); end
                    2'd2:    begin w_ma = 32'(r_ma[LW-1:32]);  w_mb = r_mb[31:0]; end
                    default: begin w_ma = 32'(r_ma[LW-1:32]);  w_mb = 32'(r_mb[LW-1:32]); end
                endcase
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
        w_prod = w_ma * w_mb;
    end

    logic w_psign;
    assign w_psign = w_diff[24] ^ w_sum[24];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_min_len <= ppf_pkg::MIN_LEN_RESET;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_ovalid <= 1'b0;
            r_dstart <= 1'b0;
            r_k      <= '0;
            r_ph     <= '0;
            for (int i = 0; i < 3; i++) begin
                r_first[i] <= '0;
                r_prev[i]  <= '0;
                r_csum[i]  <= '0;
                r_nsum[i]  <= '0;
            end
        end else begin
            r_dstart <= ((r_state == S_DIVN) && !w_degen) || ((r_state == S_WAITN) && w_ddone);
            if (i_cfg_we) begin
                r_min_len <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        r_last <= i_last_vertex;
                        r_cur[0] <= i_pos_x;
                        r_cur[1] <= i_pos_y;
                        r_cur[2] <= i_pos_z;
                        r_k <= '0;
                        if (32'(r_count) >= ppf_pkg::MAX_LOOP_LEN) begin
                            r_ovf <= 1'b1;
                            r_state <= i_last_vertex ? S_FIN : S_IDLE;
                        end else begin
                            r_count <= r_count + KW'(1);
                            r_csum[0] <= r_csum[0] + CW'(i_pos_x);
                            r_csum[1] <= r_csum[1] + CW'(i_pos_y);
                            r_csum[2] <= r_csum[2] + CW'(i_pos_z);
                            if (r_count == '0) begin
                                r_first[0] <= i_pos_x;
                                r_first[1] <= i_pos_y;
                                r_first[2] <= i_pos_z;
                                r_prev[0] <= i_pos_x;
                                r_prev[1] <= i_pos_y;
                                r_prev[2] <= i_pos_z;
                                r_state <= i_last_vertex ? S_PAIR : S_IDLE;
                            end else begin
                                r_state <= S_PAIR;
                            end
                        end
                    end
                end
                S_PAIR: begin
                    r_nsum[r_k] <= r_nsum[r_k] +
                        (w_psign ? -NW'(w_prod) : NW'(w_prod));
                    if (r_k == 2'd2) begin
                        r_k <= '0;
                        r_prev <= r_cur;
                        if (r_last) begin
                            r_cur <= r_first;
                            r_state <= S_CLOSE;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_k <= r_k + 2'd1;
                    end
                end
                S_CLOSE: begin
                    r_nsum[r_k] <= r_nsum[r_k] +
                        (w_psign ? -NW'(w_prod) : NW'(w_prod));
                    if (r_k == 2'd2) begin
                        r_k <= '0;
                        r_state <= S_FIN;
                    end else begin
                        r_k <= r_k + 2'd1;
                    end
                end
                S_FIN: begin
                    r_acc <= '0;
                    r_ph  <= '0;
                    r_k   <= '0;
                    if (r_ovf) begin
                        r_status <= ppf_pkg::ST_OVERFLOW;
                        r_state <= S_OUT;
                    end else if (r_count < KW'(3)) begin
                        r_status <= ppf_pkg::ST_FEW;
                        r_state <= S_OUT;
                    end else begin
                        r_status <= ppf_pkg::ST_OK;
                        r_ma <= LW'(w_nmag);
                        r_mb <= LW'(w_nmag);
                        r_state <= S_SQ;
                    end
                end
                // four partial products per component, then one drain step
                S_SQ: begin
                    r_prod <= w_prod;
                    if (r_ph != 4'd0) begin
                        case (r_ph[2:0] - 3'd1)
                            3'd0:    r_acc <= r_acc + SW'(r_prod);
                            3'd1,
                            3'd2:    r_acc <= r_acc + (SW'(r_prod) << 32);
                            default: r_acc <= r_acc + (SW'(r_prod) << 64);
                        endcase
                    end
                    if (r_ph == 4'd4) begin
                        r_ph <= '0;
                        if (r_k == 2'd2) begin
                            r_sq <= r_acc + (SW'(r_prod) << 64);
                            r_len <= '0;
                            r_bit <= 6'd59;
                            r_state <= S_SQRT;
                        end else begin
                            r_k <= r_k + 2'd1;
                            r_state <= S_SQ;
                            r_ma <= LW'(r_nsum[r_k + 2'd1][NW-1] ?
                                NW'(-r_nsum[r_k + 2'd1]) : NW'(r_nsum[r_k + 2'd1]));
                            r_mb <= LW'(r_nsum[r_k + 2'd1][NW-1] ?
                                NW'(-r_nsum[r_k + 2'd1]) : NW'(r_nsum[r_k + 2'd1]));
                        end
                    end else begin
                        r_ph <= r_ph + 4'd1;
                    end
                end
                // bit-serial root: square the candidate on the shared multiplier
                S_SQRT: begin
                    r_cand <= r_len | (LW'(1) << r_bit);
                    r_ma <= r_len | (LW'(1) << r_bit);
                    r_mb <= r_len | (LW'(1) << r_bit);
                    r_acc <= '0;
                    r_ph <= '0;
                    r_state <= S_SQRT2;
                end
                S_SQRT2: begin
                    r_prod <= w_prod;
                    if (r_ph != 4'd0) begin
                        case (r_ph[2:0] - 3'd1)
                            3'd0:    r_acc <= r_acc + SW'(r_prod);
                            3'd1,
                            3'd2:    r_acc <= r_acc + (SW'(r_prod) << 32);
                            default: r_acc <= r_acc + (SW'(r_prod) << 64);
                        endcase
                    end
                    if (r_ph == 4'd4) begin
                        if ((r_acc + (SW'(r_prod) << 64)) <= r_sq) begin
                            r_len <= r_cand;
                        end
                        if (r_bit == 6'd0) begin
                            r_state <= S_DIVN;
                            r_k <= '0;
                        end else begin
                            r_bit <= r_bit - 6'd1;
                            r_state <= S_SQRT;
                        end
                    end else begin
                        r_ph <= r_ph + 4'd1;
                    end
                end
                S_DIVN: begin
                    if (w_degen) begin
                        r_status <= ppf_pkg::ST_DEGEN;
                        r_state <= S_OUT;
                    end else begin
                        r_dnum <= (SW'(w_nmag) << 30) + SW'(r_len >> 1);
                        r_dden <= r_len;
                        r_dbits <= 7'd120;
                        r_state <= S_WAITN;
                    end
                end
                S_WAITN: begin
                    if (w_ddone) begin
                        r_nrm[r_k] <= r_nsum[r_k][NW-1] ? -$signed(w_nq) : $signed(w_nq);
                        r_dnum <= SW'(w_cmag) + SW'(r_count >> 1);
                        r_dden <= LW'(r_count);
                        r_dbits <= 7'd120;
                        r_state <= S_WAITC;
                    end
                end
                S_WAITC: begin
                    if (w_ddone) begin
                        r_cen[r_k] <= r_csum[r_k][CW-1] ? -24'(w_dquot) : 24'(w_dquot);
                        if (r_k == 2'd2) begin
                            r_state <= S_OUT;
                        end else begin
                            r_k <= r_k + 2'd1;
                            r_state <= S_DIVC;
                        end
                    end
                end
                S_DIVC: begin
                    r_state <= S_DIVN;
                end
                S_OUT: begin
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        r_out_cx <= (r_status == ppf_pkg::ST_OK) ? r_cen[0] : '0;
                        r_out_cy <= (r_status == ppf_pkg::ST_OK) ? r_cen[1] : '0;
                        r_out_cz <= (r_status == ppf_pkg::ST_OK) ? r_cen[2] : '0;
                        r_out_nx <= (r_status == ppf_pkg::ST_OK) ? r_nrm[0] : '0;
                        r_out_ny <= (r_status == ppf_pkg::ST_OK) ? r_nrm[1] : '0;
                        r_out_nz <= (r_status == ppf_pkg::ST_OK) ? r_nrm[2] : '0;
                        r_out_st <= r_status;
                        r_count <= '0;
                        r_ovf <= 1'b0;
                        for (int i = 0; i < 3; i++) begin
                            r_first[i] <= '0;
                            r_prev[i]  <= '0;
                            r_csum[i]  <= '0;
                            r_nsum[i]  <= '0;
                        end
                    end else if (!i_stall) begin
                        r_ovalid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid    = r_ovalid;
    assign o_center_x = r_out_cx;
    assign o_center_y = r_out_cy;
    assign o_center_z = r_out_cz;
    assign o_normal_x = r_out_nx;
    assign o_normal_y = r_out_ny;
    assign o_normal_z = r_out_nz;
    assign o_status   = r_out_st;

`ifndef NO_ASSERTIONS
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall) else $error("input taken while busy");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= ppf_pkg::MAX_LOOP_LEN) else $error("count past bound");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && i_stall) |=> r_ovalid && $stable(o_status))
        else $error("result dropped");
    a_ok_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && o_status != ppf_pkg::ST_OK) |-> (o_normal_x == '0))
        else $error("failed result carries normal");
`endif

endmodule

[verif/tb.sv]
module tb;

    typedef struct {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
        logic               last;
    } vertex_t;

    typedef struct {
        logic signed [23:0] cx;
        logic signed [23:0] cy;
        logic signed [23:0] cz;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] nz;
        logic [1:0]         st;
    } fit_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [23:0] i_pos_x = '0;
    logic signed [23:0] i_pos_y = '0;
    logic signed [23:0] i_pos_z = '0;
    logic               i_last_vertex = 1'b0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [23:0] o_center_x, o_center_y, o_center_z;
    logic signed [31:0] o_normal_x, o_normal_y, o_normal_z;
    logic [1:0]         o_status;
    logic               i_cfg_we = 1'b0;
    logic [31:0]        i_cfg_data = '0;

    polygon_plane_fit_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .i_last_vertex(i_last_vertex),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_center_x(o_center_x), .o_center_y(o_center_y), .o_center_z(o_center_z),
        .o_normal_x(o_normal_x), .o_normal_y(o_normal_y), .o_normal_z(o_normal_z),
        .o_status(o_status),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    vertex_t     vertex_q[$];
    fit_t        fit_q[$];
    longint      first_p[3], prev_p[3], cur_p[3], csum[3], nsum[3];
    int unsigned vcount;
    bit          ovf;
    logic [31:0] min_len;
    int          mismatches, loops_done, results_seen, status_seen[4];
    int          send_gap, stall_left, idle_cycles;
    bit          calm;

    function automatic void clear_loop();
        for (int k = 0; k < 3; k++) begin
            first_p[k] = 0;
            prev_p[k] = 0;
            csum[k] = 0;
            nsum[k] = 0;
        end
        vcount = 0;
        ovf = 0;
    endfunction

    function automatic void add_pair(bit closing);
        longint b1, b2;
        for (int k = 0; k < 3; k++) begin
            b1 = closing ? first_p[(k+1)%3] : cur_p[(k+1)%3];
            b2 = closing ? first_p[(k+2)%3] : cur_p[(k+2)%3];
            nsum[k] += (prev_p[(k+1)%3] - b1) * (prev_p[(k+2)%3] + b2);
        end
    endfunction

    function automatic void fold_vertex(vertex_t v);
        logic [127:0] sq, num, q128;
        logic [63:0]  len, cand, m, cm, q;
        longint       cen[3], nrm[3];
        logic [1:0]   st;
        fit_t         r;
        cur_p[0] = v.x;
        cur_p[1] = v.y;
        cur_p[2] = v.z;
        if (vcount >= ppf_pkg::MAX_LOOP_LEN) begin
            ovf = 1;
        end else begin
            if (vcount == 0) begin
                for (int k = 0; k < 3; k++) first_p[k] = cur_p[k];
            end else begin
                add_pair(0);
            end
            for (int k = 0; k < 3; k++) begin
                prev_p[k] = cur_p[k];
                csum[k] += cur_p[k];
            end
            vcount++;
        end
        if (!v.last) return;
        for (int k = 0; k < 3; k++) begin
            cen[k] = 0;
            nrm[k] = 0;
        end
        if (!ovf) add_pair(1);
        if (ovf) begin
            st = ppf_pkg::ST_OVERFLOW;
        end else if (vcount < 3) begin
            st = ppf_pkg::ST_FEW;
        end else begin
            sq = '0;
            for (int k = 0; k < 3; k++) begin
                m = nsum[k] < 0 ? -nsum[k] : nsum[k];
                sq += {64'd0, m} * {64'd0, m};
            end
            len = '0;
            for (int b = 59; b >= 0; b--) begin
                cand = len | (64'd1 << b);
                if ({64'd0, cand} * {64'd0, cand} <= sq) len = cand;
            end
            if (len == 0 || len < {32'd0, min_len}) begin
                st = ppf_pkg::ST_DEGEN;
            end else begin
                st = ppf_pkg::ST_OK;
                for (int k = 0; k < 3; k++) begin
                    m = nsum[k] < 0 ? -nsum[k] : nsum[k];
                    num = ({64'd0, m} << 30) + {64'd0, len >> 1};
                    q128 = num / {64'd0, len};
                    q = q128[63:0];
                    if (q > 64'd1 << 30) q = 64'd1 << 30;
                    nrm[k] = nsum[k] < 0 ? -longint'(q) : longint'(q);
                    cm = csum[k] < 0 ? -csum[k] : csum[k];
                    cm = (cm + vcount / 2) / vcount;
                    cen[k] = csum[k] < 0 ? -longint'(cm) : longint'(cm);
                end
            end
        end
        r.cx = cen[0][23:0];
        r.cy = cen[1][23:0];
        r.cz = cen[2][23:0];
        r.nx = nrm[0][31:0];
        r.ny = nrm[1][31:0];
        r.nz = nrm[2][31:0];
        r.st = st;
        fit_q.insert(fit_q.size(), r);
        loops_done++;
        status_seen[st]++;
        clear_loop();
    endfunction

    // sender side
    always @(posedge i_clk) begin
        vertex_t v;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                v.x = i_pos_x;
                v.y = i_pos_y;
                v.z = i_pos_z;
                v.last = i_last_vertex;
                fold_vertex(v);
            end
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid <= 1'b0;
                end else if (vertex_q.size() > 0) begin
                    v = vertex_q.pop_front();
                    i_pos_x <= v.x;
                    i_pos_y <= v.y;
                    i_pos_z <= v.z;
                    i_last_vertex <= v.last;
                    i_valid <= 1'b1;
                    if (!calm && $urandom_range(0, 9) == 0)
                        send_gap <= $urandom_range(1, 16);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver side and watchdog
    always @(posedge i_clk) begin
        fit_t e;
        if (i_rst_n) begin
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
                if (!calm && $urandom_range(0, 7) == 0) stall_left <= $urandom_range(1, 16);
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 6000) begin
                $display("Verification failed");
                $finish;
            end
            if (o_valid && !i_stall) begin
                results_seen++;
                if (fit_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result, status %0d", o_status);
                end else begin
                    e = fit_q.pop_front();
                    if (o_center_x !== e.cx || o_center_y !== e.cy || o_center_z !== e.cz ||
                        o_normal_x !== e.nx || o_normal_y !== e.ny || o_normal_z !== e.nz ||
                        o_status !== e.st) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch exp c=(%0d %0d %0d) n=(%0d %0d %0d) st=%0d",
                                     e.cx, e.cy, e.cz, e.nx, e.ny, e.nz, e.st);
                            $display("         got c=(%0d %0d %0d) n=(%0d %0d %0d) st=%0d",
                                     o_center_x, o_center_y, o_center_z,
                                     o_normal_x, o_normal_y, o_normal_z, o_status);
                        end
                    end
                end
            end
        end
    end

    function automatic logic signed [23:0] pick(int mode);
        case (mode)
            0: pick = 24'($urandom);
            1: pick = 24'($signed($urandom_range(0, 1023)) - 512);
            default: pick = 24'($signed($urandom_range(0, 15)) - 8);
        endcase
    endfunction

    task automatic push_vertex(logic signed [23:0] x, y, z, logic last);
        vertex_t v;
        v.x = x;
        v.y = y;
        v.z = z;
        v.last = last;
        vertex_q.insert(vertex_q.size(), v);
    endtask

    // shape: 0 full range, 1 small, 2 tiny, 3 collinear, 4 repeated point
    task automatic push_loop(int n, int shape);
        logic signed [23:0] bx, by, bz, dx, dy, dz;
        bx = pick(0);
        by = pick(0);
        bz = pick(0);
        dx = pick(2);
        dy = pick(2);
        dz = pick(2);
        for (int i = 0; i < n; i++) begin
            if (shape == 3) push_vertex(24'(i * dx), 24'(i * dy), 24'(i * dz), i == n - 1);
            else if (shape == 4) push_vertex(bx, by, bz, i == n - 1);
            else push_vertex(pick(shape), pick(shape), pick(shape), i == n - 1);
        end
    endtask

    task automatic push_random_loops(int n_items);
        int cnt, n, r;
        cnt = 0;
        while (cnt < n_items) begin
            r = $urandom_range(0, 19);
            n = (r == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
            if (r == 1) push_loop(n, 3);
            else if (r == 2) push_loop(n, 4);
            else push_loop(n, $urandom_range(0, 2));
            cnt += n;
        end
    endtask

    task automatic settle();
        while (vertex_q.size() > 0 || i_valid || fit_q.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_min_len(logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= val;
        min_len = val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        min_len = ppf_pkg::MIN_LEN_RESET;
        clear_loop();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_vertex(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 1'b1);
        push_vertex(24'sh800000, 24'sh800000, 24'sh800000, 1'b0);
        push_vertex(24'sh7FFFFF, 24'sh000000, 24'sh800000, 1'b1);
        push_vertex(24'sh7FFFFF, 24'sh800000, 24'sh000000, 1'b0);
        push_vertex(24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 1'b0);
        push_vertex(24'sh000000, 24'sh800000, 24'sh7FFFFF, 1'b1);
        push_vertex(24'sh000000, 24'sh000000, 24'sh000000, 1'b0);
        push_vertex(24'sh010000, 24'sh000000, 24'sh000000, 1'b0);
        push_vertex(24'sh010000, 24'sh010000, 24'sh000000, 1'b0);
        push_vertex(24'sh000000, 24'sh010000, 24'sh000000, 1'b1);
        push_vertex(24'sh000000, 24'sh000000, 24'sh000000, 1'b0);
        push_vertex(24'sh000000, 24'sh000000, 24'sh000001, 1'b0);
        push_vertex(24'sh000001, 24'sh000000, 24'sh000000, 1'b1);
        push_loop(3, 4);
        push_loop(4, 3);
        settle();

        write_min_len(32'd0);
        push_random_loops(280);
        push_loop(1025, 0);
        settle();

        write_min_len(32'hFFFF_FFFF);
        push_random_loops(90);
        settle();

        write_min_len(32'd4295);
        push_random_loops(90);
        settle();

        write_min_len($urandom_range(0, 32'h00FF_FFFF));
        calm = 1;
        push_random_loops(250);
        settle();
        repeat (650) @(posedge i_clk);

        $display("%0d loops checked: %0d ok, %0d short, %0d degenerate, %0d overlong",
                 loops_done, status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        $display("%0d results received, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0 && fit_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
